// ===== hw/rtl/qlsd_pkg.sv =====
`timescale 1ns / 1ps

package qlsd_pkg;

    localparam int SENSOR_W    = 12;
    localparam int ANGLE_W     = 9;
    localparam int STATUS_W    = 2;
    localparam int MIN_LVL_W   = 12;
    localparam int DZONE_W     = 13;
    // widest product of a 12-bit magnitude and 45
    localparam int PROD_W      = 18;
    // octant quotient never exceeds 45
    localparam int Q_W         = 6;
    localparam int APB_DW      = 32;
    localparam int PADDR_W     = 3;
    localparam int SAMPLES_DEF = 8;

    localparam logic [MIN_LVL_W-1:0] MIN_LVL_RST = MIN_LVL_W'(100);
    localparam logic [DZONE_W-1:0]   DZONE_RST   = DZONE_W'(20);

    localparam int DEG_45  = 45;
    localparam int DEG_90  = 90;
    localparam int DEG_180 = 180;

    // register index taken from paddr bit 2
    localparam logic REG_MIN_LIGHT = 1'b0;
    localparam logic REG_DEADZONE  = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK     = 2'd0,
        ST_DARK   = 2'd1,
        ST_SPREAD = 2'd2,
        ST_SMALL  = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_AVG,
        S_EVAL,
        S_CHECK,
        S_ANG_GO,
        S_ANG_WAIT,
        S_OUT
    } seq_state_t;

    typedef struct packed {
        logic [SENSOR_W-1:0] sensor_top_left;
        logic [SENSOR_W-1:0] sensor_top_right;
        logic [SENSOR_W-1:0] sensor_bottom_left;
        logic [SENSOR_W-1:0] sensor_bottom_right;
    } in_item_t;

    typedef struct packed {
        logic signed [ANGLE_W-1:0] angle_degrees;
        logic [STATUS_W-1:0]       status;
    } out_item_t;

    typedef struct packed {
        logic [MIN_LVL_W-1:0] light_floor;
        logic [DZONE_W-1:0]   dead_band;
    } cfg_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

    function automatic int sum_w(input int samples);
        return SENSOR_W + $clog2(samples);
    endfunction

    function automatic int div_w(input int samples);
        return (sum_w(samples) > PROD_W) ? sum_w(samples) : PROD_W;
    endfunction

endpackage

// ===== hw/rtl/qlsd_chan_if.sv =====
`timescale 1ns / 1ps

interface qlsd_chan_if #(
    parameter type T = logic
) ();
    logic valid;
    logic ready;
    T     payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// ===== hw/rtl/qlsd_apb.sv =====
`timescale 1ns / 1ps

module qlsd_apb (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [qlsd_pkg::PADDR_W-1:0]  paddr,
    input  logic [qlsd_pkg::APB_DW-1:0]   pwdata,
    output logic [qlsd_pkg::APB_DW-1:0]   prdata,
    output logic                          pready,
    output qlsd_pkg::cfg_t                cfg
);
    import qlsd_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;
    logic wr_en;
    logic sel_bit;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign sel_bit = paddr[2];

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            if (sel_bit == REG_MIN_LIGHT)
                cfg_next.light_floor = pwdata[MIN_LVL_W-1:0];
            else
                cfg_next.dead_band = pwdata[DZONE_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.light_floor <= MIN_LVL_RST;
            cfg_reg.dead_band   <= DZONE_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign prdata = (sel_bit == REG_DEADZONE) ? APB_DW'(cfg_reg.dead_band)
                                              : APB_DW'(cfg_reg.light_floor);
    assign cfg    = cfg_reg;

endmodule

// ===== hw/rtl/qlsd_div.sv =====
`timescale 1ns / 1ps

module qlsd_div #(
    parameter int DIV_W = qlsd_pkg::PROD_W
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [DIV_W-1:0]      dividend,
    input  logic [DIV_W-1:0]      divisor,
    output logic [DIV_W-1:0]      quotient,
    output qlsd_pkg::div_stat_t   stat
);
    import qlsd_pkg::*;

    localparam int STEP_W = (DIV_W > 1) ? $clog2(DIV_W) : 1;

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic [DIV_W-1:0]  rem_reg, rem_next;
    logic [DIV_W-1:0]  quo_reg, quo_next;
    logic [DIV_W-1:0]  den_reg, den_next;
    logic [DIV_W:0]    shifted;
    logic [DIV_W:0]    diff;
    logic              take;

    always_comb
    begin
        shifted   = {rem_reg, quo_reg[DIV_W-1]};
        diff      = shifted - {1'b0, den_reg};
        take      = !diff[DIV_W];
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        den_next  = den_reg;
        if (start)
        begin
            busy_next = 1'b1;
            step_next = STEP_W'(DIV_W - 1);
            rem_next  = '0;
            quo_next  = dividend;
            den_next  = divisor;
        end
        else if (busy_reg)
        begin
            // one restoring step: shift in the next dividend bit, subtract if it fits
            rem_next  = take ? diff[DIV_W-1:0] : shifted[DIV_W-1:0];
            quo_next  = {quo_reg[DIV_W-2:0], take};
            step_next = step_reg - STEP_W'(1);
            if (step_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        den_reg <= den_next;
    end

    assign quotient  = quo_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

// ===== hw/rtl/qlsd_seq.sv =====
`timescale 1ns / 1ps

module qlsd_seq #(
    parameter int   SAMPLES = qlsd_pkg::SAMPLES_DEF,
    localparam int  DIV_W   = qlsd_pkg::div_w(SAMPLES)
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  qlsd_pkg::cfg_t        cfg,
    qlsd_chan_if.sink             sample,
    qlsd_chan_if.source           result,
    output logic                  div_start,
    output logic [DIV_W-1:0]      div_dividend,
    output logic [DIV_W-1:0]      div_divisor,
    input  logic [DIV_W-1:0]      div_quotient,
    input  qlsd_pkg::div_stat_t   div_stat
);
    import qlsd_pkg::*;

    localparam int SUM_W = sum_w(SAMPLES);
    localparam int CNT_W = (SAMPLES > 1) ? $clog2(SAMPLES) : 1;
    localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(SAMPLES - 1);
    localparam int AVG_SH = SUM_W + $clog2(SAMPLES);
    localparam int RCP_W  = SUM_W + 1;
    localparam int PRD_W  = SUM_W + RCP_W;
    // ceiling reciprocal of SAMPLES: exact floor average for every SUM_W-bit sum
    localparam logic [RCP_W-1:0] AVG_RCP = RCP_W'(((1 << AVG_SH) + SAMPLES - 1) / SAMPLES);

    seq_state_t                 state_reg, state_next;
    logic [CNT_W-1:0]           cnt_reg, cnt_next;
    logic [1:0]                 idx_reg, idx_next;
    logic [SUM_W-1:0]           sum_reg [4];
    logic [SUM_W-1:0]           sum_next [4];
    logic [SENSOR_W-1:0]        avg_reg [4];
    logic [SENSOR_W-1:0]        avg_next [4];
    logic [SENSOR_W-1:0]        mx_reg, mx_next;
    logic [SENSOR_W-1:0]        mn_reg, mn_next;
    logic signed [SENSOR_W:0]   x_reg, x_next;
    logic signed [SENSOR_W:0]   y_reg, y_next;
    logic                       ge_reg, ge_next;
    logic                       xneg_reg, xneg_next;
    logic                       yneg_reg, yneg_next;
    logic [PROD_W-1:0]          num_reg, num_next;
    logic [SENSOR_W-1:0]        den_reg, den_next;
    logic signed [ANGLE_W-1:0]  ang_reg, ang_next;
    status_t                    stat_reg, stat_next;
    logic                       out_valid_reg, out_valid_next;
    out_item_t                  out_reg, out_next;

    logic [SENSOR_W-1:0]        in_arr [4];
    logic [SENSOR_W-1:0]        ax, ay;
    logic [SENSOR_W-1:0]        spread;
    logic [DZONE_W-1:0]         mag;
    logic [Q_W-1:0]             q;
    logic signed [ANGLE_W-1:0]  ang_a, ang_b;
    logic [SUM_W-1:0]           avg_src;
    logic [PRD_W-1:0]           avg_prod;
    logic                       accept;

    assign in_arr[0] = sample.payload.sensor_top_left;
    assign in_arr[1] = sample.payload.sensor_top_right;
    assign in_arr[2] = sample.payload.sensor_bottom_left;
    assign in_arr[3] = sample.payload.sensor_bottom_right;

    assign sample.ready = (state_reg == S_IDLE);
    assign accept       = sample.valid && sample.ready;

    always_comb
    begin
        ax       = x_reg[SENSOR_W] ? SENSOR_W'(-x_reg) : x_reg[SENSOR_W-1:0];
        ay       = y_reg[SENSOR_W] ? SENSOR_W'(-y_reg) : y_reg[SENSOR_W-1:0];
        spread   = mx_reg - mn_reg;
        mag      = {1'b0, ax} + {1'b0, ay};
        q        = div_quotient[Q_W-1:0];
        ang_a    = ge_reg ? ANGLE_W'(q) : ANGLE_W'(DEG_90) - ANGLE_W'(q);
        ang_b    = xneg_reg ? ANGLE_W'(DEG_180) - ang_a : ang_a;
        avg_src  = sum_reg[idx_reg];
        avg_prod = PRD_W'(avg_src) * PRD_W'(AVG_RCP);
    end

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        idx_next       = idx_reg;
        sum_next       = sum_reg;
        avg_next       = avg_reg;
        mx_next        = mx_reg;
        mn_next        = mn_reg;
        x_next         = x_reg;
        y_next         = y_reg;
        ge_next        = ge_reg;
        xneg_next      = xneg_reg;
        yneg_next      = yneg_reg;
        num_next       = num_reg;
        den_next       = den_reg;
        ang_next       = ang_reg;
        stat_next      = stat_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && !result.ready;
        div_start      = 1'b0;
        div_dividend   = DIV_W'(num_reg);
        div_divisor    = DIV_W'(den_reg);

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    for (int i = 0; i < 4; i++)
                        sum_next[i] = sum_reg[i] + SUM_W'(in_arr[i]);
                    if (cnt_reg == LAST_CNT)
                    begin
                        cnt_next   = '0;
                        idx_next   = '0;
                        state_next = S_AVG;
                    end
                    else
                    begin
                        cnt_next = cnt_reg + CNT_W'(1);
                    end
                end
            end
            S_AVG:
            begin
                // one sensor a cycle: multiply by the reciprocal, keep the high part
                avg_next[idx_reg] = avg_prod[AVG_SH +: SENSOR_W];
                sum_next[idx_reg] = '0;
                if (idx_reg == 2'd3)
                    state_next = S_EVAL;
                else
                    idx_next = idx_reg + 2'd1;
            end
            S_EVAL:
            begin
                mx_next = avg_reg[0];
                mn_next = avg_reg[0];
                for (int i = 1; i < 4; i++)
                begin
                    if (avg_reg[i] > mx_next)
                        mx_next = avg_reg[i];
                    if (avg_reg[i] < mn_next)
                        mn_next = avg_reg[i];
                end
                x_next     = $signed({1'b0, avg_reg[0]}) - $signed({1'b0, avg_reg[2]});
                y_next     = $signed({1'b0, avg_reg[1]}) - $signed({1'b0, avg_reg[3]});
                state_next = S_CHECK;
            end
            S_CHECK:
            begin
                ang_next   = '0;
                state_next = S_OUT;
                priority if (mx_reg < cfg.light_floor)
                    stat_next = ST_DARK;
                else if ({1'b0, spread} < cfg.dead_band)
                    stat_next = ST_SPREAD;
                else if (mag < cfg.dead_band)
                    stat_next = ST_SMALL;
                else
                begin
                    stat_next = ST_OK;
                    // a zero vector reports angle zero without dividing
                    if (ax != '0 || ay != '0)
                    begin
                        ge_next    = (ax >= ay);
                        xneg_next  = x_reg[SENSOR_W];
                        yneg_next  = y_reg[SENSOR_W];
                        num_next   = PROD_W'((ax >= ay) ? ay : ax) * PROD_W'(DEG_45);
                        den_next   = (ax >= ay) ? ax : ay;
                        state_next = S_ANG_GO;
                    end
                end
            end
            S_ANG_GO:
            begin
                div_start  = 1'b1;
                state_next = S_ANG_WAIT;
            end
            S_ANG_WAIT:
            begin
                if (div_stat.done)
                begin
                    // fold the octant into the full circle; minus 180 becomes plus 180
                    if (yneg_reg && ang_b != ANGLE_W'(DEG_180))
                        ang_next = -ang_b;
                    else
                        ang_next = ang_b;
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (!out_valid_reg || result.ready)
                begin
                    out_valid_next         = 1'b1;
                    out_next.angle_degrees = ang_reg;
                    out_next.status        = stat_reg;
                    state_next             = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < 4; i++)
                sum_reg[i] <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
            sum_reg       <= sum_next;
        end
    end

    always_ff @(posedge clk)
    begin
        avg_reg  <= avg_next;
        mx_reg   <= mx_next;
        mn_reg   <= mn_next;
        x_reg    <= x_next;
        y_reg    <= y_next;
        ge_reg   <= ge_next;
        xneg_reg <= xneg_next;
        yneg_reg <= yneg_next;
        num_reg  <= num_next;
        den_reg  <= den_next;
        ang_reg  <= ang_next;
        stat_reg <= stat_next;
        out_reg  <= out_next;
    end

    assign result.valid   = out_valid_reg;
    assign result.payload = out_reg;

endmodule

// ===== hw/rtl/quad_light_sensor_direction_top.sv =====
`timescale 1ns / 1ps

// Channel   Dir   Payload                                   Handshake
// sample    in    four 12-bit sensor samples                valid / ready
// result    out   angle_degrees (9b signed), status (2b)    valid / ready
// apb       in    light_floor @0x0, dead_band @0x4          psel/penable/pready
//
// A request that does not close the averaging window leaves the sample channel ready.
// The closing request then holds the sample channel off while the block averages
// the sensors (a reciprocal multiply per sensor), runs the checks, runs the octant
// divider when an angle is needed and loads the result; the channel stays off while
// an earlier result still waits unread.
// Reset clears sums, count and the output valid flag; thresholds return to defaults.

module quad_light_sensor_direction_top #(
    parameter int SAMPLES = qlsd_pkg::SAMPLES_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    qlsd_chan_if.sink                     sample,
    qlsd_chan_if.source                   result,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [qlsd_pkg::PADDR_W-1:0]  paddr,
    input  logic [qlsd_pkg::APB_DW-1:0]   pwdata,
    output logic [qlsd_pkg::APB_DW-1:0]   prdata,
    output logic                          pready
);
    import qlsd_pkg::*;

    localparam int DIV_W = div_w(SAMPLES);

    cfg_t             cfg;
    logic             div_start;
    logic [DIV_W-1:0] div_dividend;
    logic [DIV_W-1:0] div_divisor;
    logic [DIV_W-1:0] div_quotient;
    div_stat_t        div_stat;

    qlsd_apb u_apb (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    qlsd_div #(
        .DIV_W (DIV_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .quotient (div_quotient),
        .stat     (div_stat)
    );

    qlsd_seq #(
        .SAMPLES (SAMPLES)
    ) u_seq (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg),
        .sample       (sample),
        .result       (result),
        .div_start    (div_start),
        .div_dividend (div_dividend),
        .div_divisor  (div_divisor),
        .div_quotient (div_quotient),
        .div_stat     (div_stat)
    );

    // the divider is never restarted while a division is running
    a_div_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> !div_stat.busy)
        else $error("divider started while busy");

    // a new result is loaded only while the sample channel is held off
    a_result_after_run: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result.valid) |-> !$past(sample.ready))
        else $error("result appeared outside a compute run");

    // any failed check reports angle zero
    a_zero_angle: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && result.payload.status != ST_OK)
        |-> result.payload.angle_degrees == '0)
        else $error("non-zero angle with failing status");

    // angle stays within minus 179 to plus 180
    a_angle_range: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid |-> ($signed(result.payload.angle_degrees) >= -179 &&
                          $signed(result.payload.angle_degrees) <= 180))
        else $error("angle out of range");

endmodule

// ===== test/tb_quad_light_sensor_direction_top.sv =====
`timescale 1ns / 1ps

module tb_quad_light_sensor_direction_top;

    import qlsd_pkg::*;

    localparam int N_SAMPLES    = SAMPLES_DEF;
    localparam int FULL_TURN    = 360;
    localparam int SENSOR_MAX   = (1 << SENSOR_W) - 1;
    localparam int DRAIN_CYCLES = 120;
    localparam int WATCHDOG     = 5000;
    localparam int HOLD_START   = 1500;
    localparam int HOLD_LEN     = 1200;

    localparam logic [PADDR_W-1:0] ADDR_MIN_LIGHT = {REG_MIN_LIGHT, 2'b00};
    localparam logic [PADDR_W-1:0] ADDR_DEADZONE  = {REG_DEADZONE, 2'b00};

    logic clk;
    logic rst_n;
    logic psel;
    logic penable;
    logic pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [APB_DW-1:0]  pwdata;
    logic [APB_DW-1:0]  prdata;
    logic               pready;

    qlsd_chan_if #(.T(in_item_t))  sample_if ();
    qlsd_chan_if #(.T(out_item_t)) result_if ();

    quad_light_sensor_direction_top #(
        .SAMPLES (N_SAMPLES)
    ) u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .sample  (sample_if),
        .result  (result_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    in_item_t  sample_backlog[$];
    out_item_t predicted_results[$];

    // shadow of the block's registers and accumulators
    logic [MIN_LVL_W-1:0] shadow_min_light;
    logic [DZONE_W-1:0]   shadow_deadzone;
    int unsigned          window_sums[4];
    int unsigned          window_fill;

    int n_queued;
    int n_taken;
    int errors;
    int src_idle_pct;
    int sink_idle_pct;
    int rx_cycle;
    int quiet_cycles;

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic int mag(input int v);
        return (v < 0) ? -v : v;
    endfunction

    function automatic int octant_deg(input int y, input int x);
        int ax;
        int ay;
        int a;
        if (x == 0 && y == 0)
            return 0;
        ax = mag(x);
        ay = mag(y);
        if (ax >= ay)
            a = (ay * DEG_45) / ax;
        else
            a = DEG_90 - (ax * DEG_45) / ay;
        if (x < 0)
            a = DEG_180 - a;
        if (y < 0)
            a = -a;
        while (a > DEG_180)
            a -= FULL_TURN;
        while (a <= -DEG_180)
            a += FULL_TURN;
        return a;
    endfunction

    // accumulate one request; the request closing the window yields a result
    function automatic void absorb_sample(input in_item_t s);
        int        avg[4];
        int        hi;
        int        lo;
        int        x;
        int        y;
        int        ang;
        int        i;
        status_t   st;
        out_item_t r;
        window_sums[0] += s.sensor_top_left;
        window_sums[1] += s.sensor_top_right;
        window_sums[2] += s.sensor_bottom_left;
        window_sums[3] += s.sensor_bottom_right;
        window_fill++;
        if (window_fill < N_SAMPLES)
            return;
        for (i = 0; i < 4; i++)
        begin
            avg[i] = int'(window_sums[i] / N_SAMPLES);
            window_sums[i] = 0;
        end
        window_fill = 0;
        hi = avg[0];
        lo = avg[0];
        for (i = 1; i < 4; i++)
        begin
            if (avg[i] > hi)
                hi = avg[i];
            if (avg[i] < lo)
                lo = avg[i];
        end
        x = avg[0] - avg[2];
        y = avg[1] - avg[3];
        ang = 0;
        if (hi < int'(shadow_min_light))
            st = ST_DARK;
        else if ((hi - lo) < int'(shadow_deadzone))
            st = ST_SPREAD;
        else if ((mag(x) + mag(y)) < int'(shadow_deadzone))
            st = ST_SMALL;
        else
        begin
            st = ST_OK;
            ang = octant_deg(y, x);
        end
        r.angle_degrees = ANGLE_W'(ang);
        r.status = st;
        predicted_results.push_back(r);
    endfunction

    function automatic logic [SENSOR_W-1:0] sat12(input int v);
        if (v < 0)
            return '0;
        if (v > SENSOR_MAX)
            return SENSOR_W'(SENSOR_MAX);
        return SENSOR_W'(v);
    endfunction

    task automatic queue_sample(input int tl, input int tr, input int bl, input int br);
        in_item_t it;
        it.sensor_top_left     = sat12(tl);
        it.sensor_top_right    = sat12(tr);
        it.sensor_bottom_left  = sat12(bl);
        it.sensor_bottom_right = sat12(br);
        sample_backlog.push_back(it);
        n_queued++;
    endtask

    task automatic queue_flat_window(input int tl, input int tr, input int bl, input int br);
        int k;
        for (k = 0; k < N_SAMPLES; k++)
            queue_sample(tl, tr, bl, br);
    endtask

    // one window of random content, some modes shaped to land near the decision thresholds
    task automatic queue_random_window();
        int base[4];
        int j[4];
        int mode;
        int lvl;
        int k;
        int i;
        mode = $urandom_range(0, 9);
        lvl = $urandom_range(0, SENSOR_MAX);
        for (i = 0; i < 4; i++)
        begin
            j[i] = 0;
            case (mode)
                0, 1: base[i] = 0;
                5, 6:
                begin
                    base[i] = lvl + $urandom_range(0, int'(shadow_deadzone) + 8)
                              - int'(shadow_deadzone) / 2;
                    j[i] = 2;
                end
                7:
                begin
                    base[i] = $urandom_range(0, int'(shadow_min_light) + 30);
                    j[i] = 4;
                end
                8: base[i] = $urandom_range(0, 1) * SENSOR_MAX;
                default:
                begin
                    base[i] = $urandom_range(0, SENSOR_MAX);
                    j[i] = $urandom_range(0, 40);
                end
            endcase
        end
        for (k = 0; k < N_SAMPLES; k++)
        begin
            if (mode <= 1)
                queue_sample($urandom_range(0, SENSOR_MAX), $urandom_range(0, SENSOR_MAX),
                             $urandom_range(0, SENSOR_MAX), $urandom_range(0, SENSOR_MAX));
            else
                queue_sample(base[0] + $urandom_range(0, 2 * j[0]) - j[0],
                             base[1] + $urandom_range(0, 2 * j[1]) - j[1],
                             base[2] + $urandom_range(0, 2 * j[2]) - j[2],
                             base[3] + $urandom_range(0, 2 * j[3]) - j[3]);
        end
    endtask

    task automatic queue_random_windows(input int n);
        int w;
        for (w = 0; w < n; w++)
            queue_random_window();
    endtask

    // hold until every request is taken and every result is back, then let the divider settle
    task automatic drain();
        while (n_taken != n_queued || predicted_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic apb_write(input logic [PADDR_W-1:0] addr, input logic [APB_DW-1:0] data);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr[2] == REG_MIN_LIGHT)
            shadow_min_light = data[MIN_LVL_W-1:0];
        else
            shadow_deadzone = data[DZONE_W-1:0];
    endtask

    // garbage above the register width must be dropped by the block
    task automatic set_thresholds(input int min_light, input int deadzone);
        apb_write(ADDR_MIN_LIGHT, ($urandom() << MIN_LVL_W) | APB_DW'(min_light));
        apb_write(ADDR_DEADZONE, ($urandom() << DZONE_W) | APB_DW'(deadzone));
    endtask

    // sender
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            sample_if.valid <= 1'b0;
        else if (!sample_if.valid || sample_if.ready)
        begin
            if (sample_backlog.size() != 0 && $urandom_range(0, 99) >= src_idle_pct)
            begin
                sample_if.valid   <= 1'b1;
                sample_if.payload <= sample_backlog.pop_front();
            end
            else
                sample_if.valid <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && sample_if.valid && sample_if.ready)
        begin
            n_taken++;
            absorb_sample(sample_if.payload);
        end
    end

    // receiver, with one long hold-off so the block backs up into the sample channel
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_if.ready <= 1'b0;
            rx_cycle <= 0;
        end
        else
        begin
            rx_cycle <= rx_cycle + 1;
            if (rx_cycle >= HOLD_START && rx_cycle < HOLD_START + HOLD_LEN)
                result_if.ready <= 1'b0;
            else
                result_if.ready <= ($urandom_range(0, 99) >= sink_idle_pct);
        end
    end

    always @(posedge clk)
    begin : result_check
        out_item_t want;
        if (rst_n && result_if.valid && result_if.ready)
        begin
            if (predicted_results.size() == 0)
            begin
                $display("%0t: unrequested result angle %0d status %0d", $time,
                         result_if.payload.angle_degrees, result_if.payload.status);
                errors++;
            end
            else
            begin
                want = predicted_results.pop_front();
                if (result_if.payload.angle_degrees !== want.angle_degrees)
                begin
                    $display("%0t: angle_degrees expected %0d got %0d", $time,
                             want.angle_degrees, result_if.payload.angle_degrees);
                    errors++;
                end
                if (result_if.payload.status !== want.status)
                begin
                    $display("%0t: status expected %0d got %0d", $time,
                             want.status, result_if.payload.status);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((sample_if.valid && sample_if.ready) || (result_if.valid && result_if.ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG)
            begin
                $display("tb_quad_light_sensor_direction_top: errors");
                $finish;
            end
        end
    end

    initial
    begin
        clk               = 1'b0;
        rst_n             = 1'b0;
        psel              = 1'b0;
        penable           = 1'b0;
        pwrite            = 1'b0;
        paddr             = '0;
        pwdata            = '0;
        sample_if.valid   = 1'b0;
        sample_if.payload = '0;
        result_if.ready   = 1'b0;
        shadow_min_light  = MIN_LVL_RST;
        shadow_deadzone   = DZONE_RST;
        window_sums       = '{0, 0, 0, 0};
        window_fill       = 0;
        n_queued          = 0;
        n_taken           = 0;
        errors            = 0;
        quiet_cycles      = 0;
        src_idle_pct      = 28;
        sink_idle_pct     = 47;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // reset thresholds: full-scale diagonals, the -180 wrap, dark, flat spread, short vector
        queue_flat_window(SENSOR_MAX, 0, 0, SENSOR_MAX);
        queue_flat_window(0, 2000, SENSOR_MAX, 2001);
        queue_flat_window(50, 50, 50, 50);
        queue_flat_window(1000, 1005, 1010, 1000);
        queue_flat_window(1000, 1030, 1000, 1020);
        queue_flat_window(0, SENSOR_MAX, SENSOR_MAX, 0);
        drain();

        set_thresholds($urandom_range(50, 600), $urandom_range(10, 200));
        queue_random_windows(31);
        drain();

        src_idle_pct  = 47;
        sink_idle_pct = 28;
        set_thresholds(0, 0);
        // zero vector passes every check with a zero deadzone
        queue_flat_window(1234, 1234, 1234, 1234);
        queue_random_windows(25);
        drain();

        src_idle_pct  = 0;
        sink_idle_pct = 0;
        set_thresholds(SENSOR_MAX, (1 << DZONE_W) - 1);
        queue_flat_window(SENSOR_MAX, SENSOR_MAX, SENSOR_MAX, SENSOR_MAX);
        queue_random_windows(5);
        drain();

        set_thresholds($urandom_range(0, 1500), $urandom_range(0, 400));
        queue_random_windows(31);
        drain();

        if (errors == 0)
            $display("tb_quad_light_sensor_direction_top: clean");
        else
            $display("tb_quad_light_sensor_direction_top: errors");
        $finish;
    end

endmodule

// ===== sim.f =====
hw/rtl/qlsd_pkg.sv
hw/rtl/qlsd_chan_if.sv
hw/rtl/qlsd_apb.sv
hw/rtl/qlsd_div.sv
hw/rtl/qlsd_seq.sv
hw/rtl/quad_light_sensor_direction_top.sv
test/tb_quad_light_sensor_direction_top.sv
